/* sv/nsc_pkg.sv */
`timescale 1ns / 1ps
package nsc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int INSET_BITS    = 15;
  localparam int UV_BITS       = 16;
  localparam int SCREEN_BITS   = 15;
  localparam int EDGE_BITS     = 18;
  localparam int SPAN_BITS     = 17;
  localparam int PROD_BITS     = 35;
  localparam int NUM_W         = 36;
  localparam int DEN_W         = 18;
  localparam int QUO_W         = 37;
  localparam int DIV_CNT_W     = 6;
  localparam int NDC_FRAC_BITS = 13;
  localparam int NDC_BITS      = 16;
  localparam int COLOR_BITS    = 32;
  localparam int PATCH_BITS    = 4;
  localparam int CORNER_BITS   = 2;
  localparam int LERP_LANES    = 4;
  localparam int DIV_LANES     = 8;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W     = 1;

  localparam logic [PATCH_BITS-1:0]  LAST_PATCH = 4'd8;
  localparam logic [CORNER_BITS-1:0] CORNER_BR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 15'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 15'd768;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] widget_x0;
    logic signed [COORD_BITS-1:0] widget_y0;
    logic signed [COORD_BITS-1:0] widget_x1;
    logic signed [COORD_BITS-1:0] widget_y1;
    logic [INSET_BITS-1:0]        inner_left;
    logic [INSET_BITS-1:0]        inner_top;
    logic [INSET_BITS-1:0]        inner_right;
    logic [INSET_BITS-1:0]        inner_bottom;
    logic [63:0]                  uv_outer;
    logic [63:0]                  uv_inner;
    logic [63:0]                  clip_box;
    logic [COLOR_BITS-1:0]        vertex_color;
  } item_t;

  typedef struct packed {
    logic signed [NDC_BITS-1:0] ndc_x;
    logic signed [NDC_BITS-1:0] ndc_y;
    logic [UV_BITS-1:0]         tex_u;
    logic [UV_BITS-1:0]         tex_v;
    logic [COLOR_BITS-1:0]      out_color;
    logic [PATCH_BITS-1:0]      patch_index;
    logic [CORNER_BITS-1:0]     corner_index;
    logic                       last;
  } vertex_t;

  // one kept patch: original span, clipped span, texture ends
  typedef struct packed {
    logic signed [EDGE_BITS-1:0] x0;
    logic signed [EDGE_BITS-1:0] x1;
    logic signed [EDGE_BITS-1:0] ox0;
    logic signed [EDGE_BITS-1:0] ox1;
    logic signed [EDGE_BITS-1:0] y0;
    logic signed [EDGE_BITS-1:0] y1;
    logic signed [EDGE_BITS-1:0] oy0;
    logic signed [EDGE_BITS-1:0] oy1;
    logic [UV_BITS-1:0]          u0;
    logic [UV_BITS-1:0]          u1;
    logic [UV_BITS-1:0]          v0;
    logic [UV_BITS-1:0]          v1;
    logic [COLOR_BITS-1:0]       color;
    logic [PATCH_BITS-1:0]       patch;
    logic                        last;
  } patch_t;

endpackage

/* sv/nsc_front.sv */
`timescale 1ns / 1ps
module nsc_front import nsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  output logic   full_o,
  input  logic   q_full_i,
  output logic   q_push_o,
  output patch_t q_data_o
);

  item_t                  item_q;
  logic                   item_v_q;
  logic [PATCH_BITS-1:0]  idx_q;

  logic signed [EDGE_BITS-1:0] xs [4];
  logic signed [EDGE_BITS-1:0] ys [4];
  logic [UV_BITS-1:0]          us [4];
  logic [UV_BITS-1:0]          vs [4];
  logic signed [EDGE_BITS-1:0] cx0, cy0, cx1, cy1, wdt, hgt;
  logic [2:0]                  row_on, col_on;
  logic [8:0]                  keep;
  logic [1:0]                  cur_r, cur_c;
  logic                        keep_cur, later_any, advance, fin, accept;

  always_comb begin
    xs[0] = EDGE_BITS'(item_q.widget_x0);
    xs[1] = EDGE_BITS'(item_q.widget_x0)
          + $signed({{(EDGE_BITS-INSET_BITS){1'b0}}, item_q.inner_left});
    xs[2] = EDGE_BITS'(item_q.widget_x0)
          + $signed({{(EDGE_BITS-INSET_BITS){1'b0}}, item_q.inner_right});
    xs[3] = EDGE_BITS'(item_q.widget_x1);
    ys[0] = EDGE_BITS'(item_q.widget_y0);
    ys[1] = EDGE_BITS'(item_q.widget_y0)
          + $signed({{(EDGE_BITS-INSET_BITS){1'b0}}, item_q.inner_top});
    ys[2] = EDGE_BITS'(item_q.widget_y0)
          + $signed({{(EDGE_BITS-INSET_BITS){1'b0}}, item_q.inner_bottom});
    ys[3] = EDGE_BITS'(item_q.widget_y1);
    us[0] = item_q.uv_outer[15:0];
    us[1] = item_q.uv_inner[15:0];
    us[2] = item_q.uv_inner[47:32];
    us[3] = item_q.uv_outer[47:32];
    vs[0] = item_q.uv_outer[31:16];
    vs[1] = item_q.uv_inner[31:16];
    vs[2] = item_q.uv_inner[63:48];
    vs[3] = item_q.uv_outer[63:48];
    cx0 = EDGE_BITS'($signed(item_q.clip_box[15:0]));
    cy0 = EDGE_BITS'($signed(item_q.clip_box[31:16]));
    cx1 = EDGE_BITS'($signed(item_q.clip_box[47:32]));
    cy1 = EDGE_BITS'($signed(item_q.clip_box[63:48]));
    wdt = xs[3] - xs[0];
    hgt = ys[3] - ys[0];
    row_on[0] = item_q.inner_top != '0;
    row_on[1] = 1'b1;
    row_on[2] = $signed({{(EDGE_BITS-INSET_BITS){1'b0}}, item_q.inner_bottom}) < hgt;
    col_on[0] = item_q.inner_left != '0;
    col_on[1] = 1'b1;
    col_on[2] = $signed({{(EDGE_BITS-INSET_BITS){1'b0}}, item_q.inner_right}) < wdt;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep[r*3+c] = row_on[r] && col_on[c]
                   && (xs[c+1] > xs[c]) && (ys[r+1] > ys[r])
                   && (xs[c] < cx1) && (xs[c+1] > cx0)
                   && (ys[r] < cy1) && (ys[r+1] > cy0);
      end
    end
  end

  always_comb begin
    cur_r = (idx_q >= 4'd6) ? 2'd2 : (idx_q >= 4'd3) ? 2'd1 : 2'd0;
    cur_c = 2'(idx_q - 4'(cur_r) * 4'd3);
    keep_cur = keep[idx_q];
    later_any = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if ((PATCH_BITS'(k) > idx_q) && keep[k]) later_any = 1'b1;
    end
  end

  always_comb begin
    q_data_o.x0    = xs[cur_c];
    q_data_o.x1    = xs[2'(cur_c + 2'd1)];
    q_data_o.y0    = ys[cur_r];
    q_data_o.y1    = ys[2'(cur_r + 2'd1)];
    q_data_o.ox0   = (q_data_o.x0 > cx0) ? q_data_o.x0 : cx0;
    q_data_o.ox1   = (q_data_o.x1 < cx1) ? q_data_o.x1 : cx1;
    q_data_o.oy0   = (q_data_o.y0 > cy0) ? q_data_o.y0 : cy0;
    q_data_o.oy1   = (q_data_o.y1 < cy1) ? q_data_o.y1 : cy1;
    q_data_o.u0    = us[cur_c];
    q_data_o.u1    = us[2'(cur_c + 2'd1)];
    q_data_o.v0    = vs[cur_r];
    q_data_o.v1    = vs[2'(cur_r + 2'd1)];
    q_data_o.color = item_q.vertex_color;
    q_data_o.patch = idx_q;
    q_data_o.last  = !later_any;
  end

  // a dropped patch advances the scan without waiting, a kept one waits for queue room
  assign advance  = item_v_q && (!keep_cur || !q_full_i);
  assign fin      = advance && (idx_q == LAST_PATCH);
  assign full_o   = item_v_q && !fin;
  assign accept   = push_i && !full_o;
  assign q_push_o = item_v_q && keep_cur && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (accept) begin
        item_v_q <= 1'b1;
        idx_q    <= '0;
      end else if (advance) begin
        item_v_q <= !fin;
        idx_q    <= PATCH_BITS'(idx_q + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

/* sv/nsc_fifo.sv */
`timescale 1ns / 1ps
module nsc_fifo import nsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  patch_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output patch_t data_o
);

  patch_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_wr, do_rd;

  assign full_o  = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wr_q <= FIFO_PTR_W'(wr_q + 1'b1);
      if (do_rd) rd_q <= FIFO_PTR_W'(rd_q + 1'b1);
      if (do_wr && !do_rd) begin
        cnt_q <= (FIFO_PTR_W+1)'(cnt_q + 1'b1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= (FIFO_PTR_W+1)'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/nsc_div.sv */
`timescale 1ns / 1ps
// floor(num / den) for den > 0, one quotient bit per cycle
module nsc_div import nsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    rdy_o,
  output logic signed [QUO_W-1:0] quo_o
);

  logic                 run_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     q_q;
  logic [DEN_W-1:0]     rem_q, den_q, rem_nx;
  logic signed [QUO_W-1:0] magw;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;

  always_comb begin
    // negative dividend: ceil of magnitude gives floor after negation
    if (num_i < 0) begin
      magw = -QUO_W'(num_i) + $signed({{(QUO_W-DEN_W){1'b0}}, den_i}) - QUO_W'(1);
    end else begin
      magw = QUO_W'(num_i);
    end
    rem_sh = {rem_q, q_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
  end

  assign rdy_o = !run_q;
  assign quo_o = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= DIV_CNT_W'(cnt_q + 1'b1);
      if (cnt_q == DIV_CNT_W'(NUM_W - 1)) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i < 0;
      q_q   <= magw[NUM_W-1:0];
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      q_q   <= {q_q[NUM_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

endmodule

/* sv/nsc_back.sv */
`timescale 1ns / 1ps
module nsc_back import nsc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [SCREEN_BITS-1:0] sw_i,
  input  logic [SCREEN_BITS-1:0] sh_i,
  input  patch_t                 hd_i,
  input  logic                   hd_empty_i,
  output logic                   hd_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output vertex_t                out_o
);

  // lerp lanes: 0 u at ox0, 1 u at ox1, 2 v at oy0, 3 v at oy1
  logic signed [EDGE_BITS-1:0] lp [LERP_LANES];
  logic signed [EDGE_BITS-1:0] la [LERP_LANES];
  logic signed [EDGE_BITS-1:0] lb [LERP_LANES];
  logic [UV_BITS-1:0]          lta [LERP_LANES];
  logic [UV_BITS-1:0]          ltb [LERP_LANES];

  logic                        s2_v_q;
  patch_t                      s2_desc_q;
  logic signed [PROD_BITS-1:0] s2_prod_q [LERP_LANES];
  logic [SPAN_BITS-1:0]        s2_span_q [LERP_LANES];
  logic [LERP_LANES-1:0]       s2_eqa_q, s2_eqb_q;

  logic                        dv_busy_q;
  patch_t                      dv_desc_q;
  logic [LERP_LANES-1:0]       dv_eqa_q, dv_eqb_q;
  logic signed [NUM_W-1:0]     dnum [DIV_LANES];
  logic [DEN_W-1:0]            dden [DIV_LANES];
  logic [DIV_LANES-1:0]        drdy;
  logic signed [QUO_W-1:0]     dquo [DIV_LANES];

  logic                        em_v_q;
  logic [CORNER_BITS-1:0]      em_cnt_q;
  logic signed [NDC_BITS-1:0]  em_x_q [2];
  logic signed [NDC_BITS-1:0]  em_y_q [2];
  logic [UV_BITS-1:0]          em_u_q [2];
  logic [UV_BITS-1:0]          em_t_q [2];
  logic [COLOR_BITS-1:0]       em_color_q;
  logic [PATCH_BITS-1:0]       em_patch_q;
  logic                        em_last_q;

  logic [UV_BITS-1:0]          lval [LERP_LANES];
  logic signed [NUM_W-1:0]     sw_ext, sh_ext;
  logic                        div_start, xfer, out_pop;

  function automatic logic signed [NDC_BITS-1:0] sat16(input logic signed [QUO_W-1:0] q);
    logic signed [NDC_BITS-1:0] res;
    if (q > QUO_W'(32767)) begin
      res = 16'sh7fff;
    end else if (q < -QUO_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = q[NDC_BITS-1:0];
    end
    return res;
  endfunction

  always_comb begin
    lp[0] = hd_i.ox0; lp[1] = hd_i.ox1; lp[2] = hd_i.oy0; lp[3] = hd_i.oy1;
    la[0] = hd_i.x0;  la[1] = hd_i.x0;  la[2] = hd_i.y0;  la[3] = hd_i.y0;
    lb[0] = hd_i.x1;  lb[1] = hd_i.x1;  lb[2] = hd_i.y1;  lb[3] = hd_i.y1;
    lta[0] = hd_i.u0; lta[1] = hd_i.u0; lta[2] = hd_i.v0; lta[3] = hd_i.v0;
    ltb[0] = hd_i.u1; ltb[1] = hd_i.u1; ltb[2] = hd_i.v1; ltb[3] = hd_i.v1;
  end

  assign div_start = s2_v_q && !dv_busy_q;
  assign hd_pop_o  = !hd_empty_i && (!s2_v_q || div_start);
  assign out_pop   = pop_i && em_v_q;
  assign xfer      = dv_busy_q && (&drdy) && (!em_v_q || (out_pop && em_cnt_q == CORNER_BR));

  always_ff @(posedge clk_i) begin
    if (hd_pop_o) begin
      s2_desc_q <= hd_i;
      for (int l = 0; l < LERP_LANES; l++) begin
        s2_prod_q[l] <= PROD_BITS'($signed({1'b0, SPAN_BITS'(lp[l] - la[l])}))
                       * PROD_BITS'($signed({1'b0, ltb[l]} - {1'b0, lta[l]}));
        s2_span_q[l] <= SPAN_BITS'(lb[l] - la[l]);
        s2_eqa_q[l]  <= lp[l] == la[l];
        s2_eqb_q[l]  <= lp[l] == lb[l];
      end
    end
  end

  // rounded quotient: floor((2n + d) / 2d)
  always_comb begin
    sw_ext = $signed({{(NUM_W-SCREEN_BITS){1'b0}}, sw_i});
    sh_ext = $signed({{(NUM_W-SCREEN_BITS){1'b0}}, sh_i});
    for (int l = 0; l < LERP_LANES; l++) begin
      dnum[l] = $signed({(NUM_W-1)'(s2_prod_q[l]), 1'b0})
              + $signed({{(NUM_W-SPAN_BITS){1'b0}}, s2_span_q[l]});
      dden[l] = {s2_span_q[l], 1'b0};
    end
    dnum[4] = (NUM_W'(s2_desc_q.ox0) <<< (NDC_FRAC_BITS + 2))
            - (sw_ext <<< (NDC_FRAC_BITS + 1)) + sw_ext;
    dnum[5] = (NUM_W'(s2_desc_q.ox1) <<< (NDC_FRAC_BITS + 2))
            - (sw_ext <<< (NDC_FRAC_BITS + 1)) + sw_ext;
    dnum[6] = (sh_ext <<< (NDC_FRAC_BITS + 1)) + sh_ext
            - (NUM_W'(s2_desc_q.oy0) <<< (NDC_FRAC_BITS + 2));
    dnum[7] = (sh_ext <<< (NDC_FRAC_BITS + 1)) + sh_ext
            - (NUM_W'(s2_desc_q.oy1) <<< (NDC_FRAC_BITS + 2));
    dden[4] = {{(DEN_W-SCREEN_BITS-1){1'b0}}, sw_i, 1'b0};
    dden[5] = {{(DEN_W-SCREEN_BITS-1){1'b0}}, sw_i, 1'b0};
    dden[6] = {{(DEN_W-SCREEN_BITS-1){1'b0}}, sh_i, 1'b0};
    dden[7] = {{(DEN_W-SCREEN_BITS-1){1'b0}}, sh_i, 1'b0};
  end

  for (genvar g = 0; g < DIV_LANES; g++) begin : g_div
    nsc_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (dnum[g]),
      .den_i   (dden[g]),
      .rdy_o   (drdy[g]),
      .quo_o   (dquo[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dv_desc_q <= s2_desc_q;
      dv_eqa_q  <= s2_eqa_q;
      dv_eqb_q  <= s2_eqb_q;
    end
  end

  // unclipped edges keep their texture value exactly
  always_comb begin
    lval[0] = dv_desc_q.u0; lval[1] = dv_desc_q.u0;
    lval[2] = dv_desc_q.v0; lval[3] = dv_desc_q.v0;
    for (int l = 0; l < LERP_LANES; l++) begin
      if (dv_eqa_q[l]) begin
        lval[l] = (l < 2) ? dv_desc_q.u0 : dv_desc_q.v0;
      end else if (dv_eqb_q[l]) begin
        lval[l] = (l < 2) ? dv_desc_q.u1 : dv_desc_q.v1;
      end else begin
        lval[l] = UV_BITS'(lval[l] + dquo[l][UV_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q    <= 1'b0;
      dv_busy_q <= 1'b0;
      em_v_q    <= 1'b0;
      em_cnt_q  <= '0;
    end else begin
      if (hd_pop_o) begin
        s2_v_q <= 1'b1;
      end else if (div_start) begin
        s2_v_q <= 1'b0;
      end
      if (div_start) begin
        dv_busy_q <= 1'b1;
      end else if (xfer) begin
        dv_busy_q <= 1'b0;
      end
      if (xfer) begin
        em_v_q   <= 1'b1;
        em_cnt_q <= '0;
      end else if (out_pop) begin
        em_cnt_q <= CORNER_BITS'(em_cnt_q + 1'b1);
        if (em_cnt_q == CORNER_BR) em_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      em_u_q[0]  <= lval[0];
      em_u_q[1]  <= lval[1];
      em_t_q[0]  <= lval[2];
      em_t_q[1]  <= lval[3];
      em_x_q[0]  <= sat16(dquo[4]);
      em_x_q[1]  <= sat16(dquo[5]);
      em_y_q[0]  <= sat16(dquo[6]);
      em_y_q[1]  <= sat16(dquo[7]);
      em_color_q <= dv_desc_q.color;
      em_patch_q <= dv_desc_q.patch;
      em_last_q  <= dv_desc_q.last;
    end
  end

  assign empty_o = !em_v_q;

  always_comb begin
    out_o.ndc_x        = em_x_q[em_cnt_q[0]];
    out_o.ndc_y        = em_y_q[em_cnt_q[1]];
    out_o.tex_u        = em_u_q[em_cnt_q[0]];
    out_o.tex_v        = em_t_q[em_cnt_q[1]];
    out_o.out_color    = em_color_q;
    out_o.patch_index  = em_patch_q;
    out_o.corner_index = em_cnt_q;
    out_o.last         = em_last_q && (em_cnt_q == CORNER_BR);
  end

endmodule

/* sv/nine_slice_clip_quad_generator.sv */
`timescale 1ns / 1ps
// Nine-slice quad generator with scissor clipping. Items enter through a queue-style
// port (push/full) and vertices leave through another (empty/pop), four per kept patch
// in corner order, with last set on the final vertex of an item; an item that keeps no
// patch gives no vertex. The front scans the nine patches of an item and queues the
// kept ones; the back runs eight serial dividers side by side for each kept patch
// (texture interpolation and NDC scaling), while vertex output, patch scanning and
// division overlap. Screen size is to be written through the cfg port only while the
// block is idle, which the block itself does not enforce; a size of zero acts as one.
module nine_slice_clip_quad_generator import nsc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  item_t                  in_item_i,
  output logic                   empty,
  input  logic                   pop,
  output vertex_t                out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SCREEN_BITS-1:0] cfg_data_i
);

  logic [SCREEN_BITS-1:0] sw_q, sh_q, sw_eff, sh_eff;
  logic                   fq_push, fq_full;
  patch_t                 fq_wdata, fq_rdata;
  logic                   fq_empty, fq_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= SCREEN_W_RST;
      sh_q <= SCREEN_H_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  sw_q <= cfg_data_i;
        REG_SCREEN_HEIGHT: sh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw_eff = (sw_q == '0) ? SCREEN_BITS'(1) : sw_q;
  assign sh_eff = (sh_q == '0) ? SCREEN_BITS'(1) : sh_q;

  nsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_item_i),
    .full_o   (full),
    .q_full_i (fq_full),
    .q_push_o (fq_push),
    .q_data_o (fq_wdata)
  );

  nsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_wdata),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .data_o  (fq_rdata)
  );

  nsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sw_i       (sw_eff),
    .sh_i       (sh_eff),
    .hd_i       (fq_rdata),
    .hd_empty_i (fq_empty),
    .hd_pop_o   (fq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_item_o)
  );

endmodule

/* sv/nsc_checker.sv */
`timescale 1ns / 1ps
module nsc_checker import nsc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    empty,
  input logic    pop,
  input vertex_t out_item_o
);

  // corners of a patch come out in order without a gap
  a_corner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && out_item_o.corner_index != CORNER_BR) |=>
      (!empty && out_item_o.corner_index == CORNER_BITS'($past(out_item_o.corner_index) + 1'b1)))
    else $error("corner sequence broken");

  a_patch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && out_item_o.corner_index != CORNER_BR) |=>
      (out_item_o.patch_index == $past(out_item_o.patch_index)))
    else $error("patch changed inside a quad");

  a_new_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && out_item_o.corner_index == CORNER_BR) |=>
      (empty || out_item_o.corner_index == '0))
    else $error("quad does not start at corner zero");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.last) |-> (out_item_o.corner_index == CORNER_BR))
    else $error("last flag away from final corner");

  a_patch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.patch_index <= LAST_PATCH))
    else $error("patch index out of range");

endmodule

bind nine_slice_clip_quad_generator nsc_checker u_nsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

/* verif/nine_slice_clip_quad_generator_tb.sv */
`timescale 1ns / 1ps
module nine_slice_clip_quad_generator_tb;
  import nsc_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int ITEMS_PER_SETTING = 60;

  // expected vertex store plus the nine-slice predictor
  class vertex_scoreboard;
    vertex_t expected_q[$];
    int      errors;
    longint  scr_w;
    longint  scr_h;

    function new();
      expected_q = {};
      errors     = 0;
      scr_w      = SCREEN_W_RST;
      scr_h      = SCREEN_H_RST;
    endfunction

    function void set_screen(logic [CFG_IDX_W-1:0] idx, logic [SCREEN_BITS-1:0] val);
      if (idx == REG_SCREEN_WIDTH) scr_w = val;
      else scr_h = val;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function longint round_div(longint n, longint d);
      return floor_div(2 * n + d, 2 * d);
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint lerp_tex(longint p, longint a, longint b, longint ta, longint tb);
      if (p == a) return ta;
      if (p == b) return tb;
      return ta + round_div((p - a) * (tb - ta), b - a);
    endfunction

    function void note_item(item_t it);
      longint xs[4], ys[4], us[4], vs[4];
      longint cx0, cy0, cx1, cy1, sw, sh, one;
      longint x0, x1, y0, y1, ox0, ox1, oy0, oy1;
      longint qx[2], qy[2], qu[2], qv[2];
      bit     row_on[3], col_on[3];
      vertex_t vx;
      int     cnt;
      cnt = 0;
      one = 1 << NDC_FRAC_BITS;
      sw  = (scr_w == 0) ? 1 : scr_w;
      sh  = (scr_h == 0) ? 1 : scr_h;
      cx0 = $signed(it.clip_box[15:0]);
      cy0 = $signed(it.clip_box[31:16]);
      cx1 = $signed(it.clip_box[47:32]);
      cy1 = $signed(it.clip_box[63:48]);
      xs[0] = $signed(it.widget_x0);
      xs[3] = $signed(it.widget_x1);
      ys[0] = $signed(it.widget_y0);
      ys[3] = $signed(it.widget_y1);
      xs[1] = xs[0] + it.inner_left;
      xs[2] = xs[0] + it.inner_right;
      ys[1] = ys[0] + it.inner_top;
      ys[2] = ys[0] + it.inner_bottom;
      us[0] = it.uv_outer[15:0];
      us[1] = it.uv_inner[15:0];
      us[2] = it.uv_inner[47:32];
      us[3] = it.uv_outer[47:32];
      vs[0] = it.uv_outer[31:16];
      vs[1] = it.uv_inner[31:16];
      vs[2] = it.uv_inner[63:48];
      vs[3] = it.uv_outer[63:48];
      row_on[0] = it.inner_top > 0;
      row_on[1] = 1;
      row_on[2] = longint'(it.inner_bottom) < (ys[3] - ys[0]);
      col_on[0] = it.inner_left > 0;
      col_on[1] = 1;
      col_on[2] = longint'(it.inner_right) < (xs[3] - xs[0]);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (!row_on[r] || !col_on[c]) continue;
          x0 = xs[c]; x1 = xs[c+1]; y0 = ys[r]; y1 = ys[r+1];
          if (x1 - x0 <= 0 || y1 - y0 <= 0) continue;
          if (x0 >= cx1 || x1 <= cx0 || y0 >= cy1 || y1 <= cy0) continue;
          ox0 = (x0 > cx0) ? x0 : cx0;
          oy0 = (y0 > cy0) ? y0 : cy0;
          ox1 = (x1 < cx1) ? x1 : cx1;
          oy1 = (y1 < cy1) ? y1 : cy1;
          qx[0] = ox0; qx[1] = ox1; qy[0] = oy0; qy[1] = oy1;
          qu[0] = lerp_tex(ox0, x0, x1, us[c], us[c+1]);
          qu[1] = lerp_tex(ox1, x0, x1, us[c], us[c+1]);
          qv[0] = lerp_tex(oy0, y0, y1, vs[r], vs[r+1]);
          qv[1] = lerp_tex(oy1, y0, y1, vs[r], vs[r+1]);
          for (int k = 0; k < 4; k++) begin
            vx.ndc_x = 16'(sat16(round_div(2 * one * qx[k & 1] - one * sw, sw)));
            vx.ndc_y = 16'(sat16(round_div(one * sh - 2 * one * qy[k >> 1], sh)));
            vx.tex_u = 16'(qu[k & 1]);
            vx.tex_v = 16'(qv[k >> 1]);
            vx.out_color    = it.vertex_color;
            vx.patch_index  = PATCH_BITS'(r * 3 + c);
            vx.corner_index = CORNER_BITS'(k);
            vx.last = 1'b0;
            expected_q.push_back(vx);
            cnt++;
          end
        end
      end
      if (cnt > 0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (expected_q.size() == 0) begin
        $error("unexpected vertex %h", got);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (got.ndc_x != exp_v.ndc_x) begin
        $error("ndc_x exp %0d got %0d", exp_v.ndc_x, got.ndc_x); errors++;
      end
      if (got.ndc_y != exp_v.ndc_y) begin
        $error("ndc_y exp %0d got %0d", exp_v.ndc_y, got.ndc_y); errors++;
      end
      if (got.tex_u != exp_v.tex_u) begin
        $error("tex_u exp %0d got %0d", exp_v.tex_u, got.tex_u); errors++;
      end
      if (got.tex_v != exp_v.tex_v) begin
        $error("tex_v exp %0d got %0d", exp_v.tex_v, got.tex_v); errors++;
      end
      if (got.out_color != exp_v.out_color) begin
        $error("out_color exp %h got %h", exp_v.out_color, got.out_color); errors++;
      end
      if (got.patch_index != exp_v.patch_index) begin
        $error("patch_index exp %0d got %0d", exp_v.patch_index, got.patch_index);
        errors++;
      end
      if (got.corner_index != exp_v.corner_index) begin
        $error("corner_index exp %0d got %0d", exp_v.corner_index, got.corner_index);
        errors++;
      end
      if (got.last != exp_v.last) begin
        $error("last exp %0d got %0d", exp_v.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   push;
  logic                   full;
  item_t                  in_item;
  logic                   empty;
  logic                   pop;
  vertex_t                out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SCREEN_BITS-1:0] cfg_data;

  vertex_scoreboard sb;
  int  idle_cycles;
  int  pop_stall;

  nine_slice_clip_quad_generator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random pop stalls, check every popped vertex
  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= (pop_stall == 0);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        sb.check_vertex(out_item);
        pop_stall = $urandom_range(0, 5);
      end else if (!pop && pop_stall > 0) begin
        pop_stall = pop_stall - 1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it);
    int gap;
    gap = $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_item(it);
  endtask

  task automatic write_screen(logic [CFG_IDX_W-1:0] idx, logic [SCREEN_BITS-1:0] val);
    @(negedge clk);
    push      <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_screen(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for outstanding vertices plus the time a patch-less item may still take
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rand_uv();
    // mostly in [0, 1.0], sometimes above one
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic item_t make_item(bit tidy);
    item_t  it;
    longint w, h, x0, y0;
    if (!tidy) begin
      it = $bits(item_t)'({rand64(), rand64(), rand64(), rand64(), rand64(), $urandom()});
      return it;
    end
    w  = $urandom_range(1, 700);
    h  = $urandom_range(1, 500);
    x0 = longint'($urandom_range(0, 2200)) - 600;
    y0 = longint'($urandom_range(0, 1800)) - 500;
    it.widget_x0 = 16'(x0);
    it.widget_y0 = 16'(y0);
    it.widget_x1 = 16'(x0 + w);
    it.widget_y1 = 16'(y0 + h);
    it.inner_left   = 15'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, w));
    it.inner_top    = 15'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, h));
    it.inner_right  = 15'($urandom_range(0, 3) == 0 ? w : $urandom_range(0, w));
    it.inner_bottom = 15'($urandom_range(0, 3) == 0 ? h : $urandom_range(0, h));
    it.uv_outer = {rand_uv(), rand_uv(), rand_uv(), rand_uv()};
    it.uv_inner = {rand_uv(), rand_uv(), rand_uv(), rand_uv()};
    if ($urandom_range(0, 9) == 0)
      it.clip_box = rand64();
    else
      it.clip_box = {16'(y0 + $urandom_range(0, 600)), 16'(x0 + $urandom_range(0, 800)),
                     16'(y0 - 100 + $urandom_range(0, 300)),
                     16'(x0 - 100 + $urandom_range(0, 400))};
    it.vertex_color = $urandom();
    return it;
  endfunction

  task automatic run_directed();
    item_t it;
    // plain nine-patch fully inside a full-screen scissor
    it = '{widget_x0: 16'sd100, widget_y0: 16'sd50, widget_x1: 16'sd300,
           widget_y1: 16'sd250, inner_left: 15'd10, inner_top: 15'd20,
           inner_right: 15'd180, inner_bottom: 15'd170,
           uv_outer: {16'd32768, 16'd32768, 16'd0, 16'd0},
           uv_inner: {16'd30000, 16'd29000, 16'd2000, 16'd1000},
           clip_box: {16'sd768, 16'sd1024, 16'sd0, 16'sd0},
           vertex_color: 32'hFFFF_FFFF};
    send_item(it);
    // scissor cutting through the kept patches, right column and bottom row dropped, descending texture
    it.clip_box = {16'sd200, 16'sd250, 16'sd60, 16'sd105};
    it.uv_outer = {16'd0, 16'd0, 16'd32768, 16'd32768};
    it.vertex_color = 32'h0;
    send_item(it);
    // zero insets: centre only
    it.inner_left = 0; it.inner_top = 0; it.inner_right = 200; it.inner_bottom = 200;
    it.clip_box = {16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768};
    send_item(it);
    // texture values above one
    it.uv_outer = 64'hFFFF_8001_FFFF_8001;
    it.uv_inner = 64'h8001_FFFF_8001_FFFF;
    send_item(it);
    // inverted scissor box
    it.clip_box = {16'sd100, 16'sd150, 16'sd150, 16'sd250};
    send_item(it);
    // scissor entirely outside: nothing kept
    it.clip_box = {16'sd10, 16'sd10, 16'sd0, 16'sd0};
    send_item(it);
    // empty widget
    it.widget_x1 = 16'sd100;
    it.clip_box = {16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768};
    send_item(it);
    // coordinate extremes, saturating ndc, wide patch edges
    it = '{widget_x0: -16'sd32768, widget_y0: -16'sd32768, widget_x1: 16'sd32767,
           widget_y1: 16'sd32767, inner_left: 15'h7FFF, inner_top: 15'h7FFF,
           inner_right: 15'h7FFF, inner_bottom: 15'h7FFF,
           uv_outer: 64'h0, uv_inner: 64'hFFFF_FFFF_FFFF_FFFF,
           clip_box: {16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768},
           vertex_color: 32'hA5A5_5A5A};
    send_item(it);
    // insets beyond the widget
    it.widget_x0 = 16'sd32000; it.widget_y0 = 16'sd32000;
    it.widget_x1 = 16'sd32767; it.widget_y1 = 16'sd32767;
    send_item(it);
    it.widget_x0 = -16'sd32768; it.widget_y0 = -16'sd32768;
    it.widget_x1 = -16'sd32000; it.widget_y1 = -16'sd32000;
    it.inner_left = 1; it.inner_top = 1; it.inner_right = 15'h7FFF; it.inner_bottom = 0;
    send_item(it);
    // one-pixel patches with clip edges on patch edges
    it = '{widget_x0: 16'sd0, widget_y0: 16'sd0, widget_x1: 16'sd3, widget_y1: 16'sd3,
           inner_left: 15'd1, inner_top: 15'd1, inner_right: 15'd2, inner_bottom: 15'd2,
           uv_outer: {16'd32768, 16'd32768, 16'd0, 16'd0},
           uv_inner: {16'd1, 16'd32767, 16'd32767, 16'd1},
           clip_box: {16'sd3, 16'sd2, 16'sd1, 16'sd0}, vertex_color: 32'h1234_5678};
    send_item(it);
    for (int i = 0; i < 6; i++) send_item(make_item(1'b0));
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_item(make_item($urandom_range(0, 9) != 0));
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    push        = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_SCREEN_WIDTH;
    cfg_data    = '0;
    idle_cycles = 0;
    pop_stall   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(ITEMS_PER_SETTING);
    wait_drained();
    // zero screen size acts as one
    write_screen(REG_SCREEN_WIDTH, '0);
    write_screen(REG_SCREEN_HEIGHT, '0);
    run_directed();
    run_random(ITEMS_PER_SETTING / 2);
    wait_drained();
    write_screen(REG_SCREEN_WIDTH, 15'h7FFF);
    write_screen(REG_SCREEN_HEIGHT, 15'h7FFF);
    run_random(ITEMS_PER_SETTING);
    wait_drained();
    write_screen(REG_SCREEN_WIDTH, 15'd16384);
    write_screen(REG_SCREEN_HEIGHT, 15'd1);
    run_random(ITEMS_PER_SETTING);
    wait_drained();
    write_screen(REG_SCREEN_WIDTH, 15'($urandom_range(1, 16384)));
    write_screen(REG_SCREEN_HEIGHT, 15'($urandom_range(1, 16384)));
    run_random(ITEMS_PER_SETTING);
    wait_drained();

    if (sb.expected_q.size() != 0) begin
      $error("%0d vertices never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
